// ----- src/euler_dead_reckoning_with_gps_reset_core_assert.svh -----
// Assertion macros shared by the dead-reckoning core.
`ifndef EULER_DEAD_RECKONING_WITH_GPS_RESET_CORE_ASSERT_SVH
`define EULER_DEAD_RECKONING_WITH_GPS_RESET_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define EDR_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define EDR_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/edr_pkg.sv -----
// Package with the word types, constants and helpers of the dead-reckoning core.
package edr_pkg;

    localparam int ANGLE_BITS_DEF    = 16;
    localparam int POSITION_BITS_DEF = 48;

    localparam int REF_W  = 34;
    localparam int OUT_W  = 48;
    localparam int DISP_W = 36;
    localparam int MA_W   = 34;
    localparam int MB_W   = 32;
    localparam int MP_W   = 66;
    localparam int MR_W   = 67;
    localparam int CIDX_W = 2;

    localparam logic [CIDX_W-1:0] CFG_EAST_REF  = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_NORTH_REF = 2'd1;

    // Odd Taylor coefficients of sine over a quarter turn, Q30.
    localparam logic signed [31:0] C_A1 = 32'sd1686629713;
    localparam logic signed [31:0] C_A3 = -32'sd693598668;
    localparam logic signed [31:0] C_A5 = 32'sd85569306;
    localparam logic signed [31:0] C_A7 = -32'sd5026995;
    localparam logic signed [31:0] C_A9 = 32'sd172273;
    localparam logic [30:0]        Q30_ONE = 31'h4000_0000;

    typedef enum logic [1:0] {
        SH_NONE,
        SH_Q15,
        SH_Q30
    } edr_shift_t;

    typedef struct packed {
        logic       start;
        edr_shift_t shift;
    } edr_mul_ctl_t;

    typedef struct packed {
        logic [15:0]        yaw_angle;
        logic signed [15:0] pitch_angle;
        logic signed [15:0] roll_angle;
        logic signed [15:0] vel_forward;
        logic signed [15:0] vel_starboard;
        logic signed [15:0] vel_down;
        logic [15:0]        step_time;
        logic               gps_fix;
        logic [REF_W-1:0]   utm_east_mm;
        logic [REF_W-1:0]   utm_north_mm;
    } edr_in_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] dead_x;
        logic signed [OUT_W-1:0] dead_y;
        logic signed [OUT_W-1:0] nav_x;
        logic signed [OUT_W-1:0] nav_y;
        logic                    gps_used;
        logic                    saturated;
    } edr_out_t;

    // Arithmetic shift right by 15 with rounding half away from zero.
    function automatic logic signed [35:0] rnd15(input logic signed [49:0] v);
        logic [49:0] mag;
        logic [49:0] q;
        logic [35:0] q36;
        mag = v[49] ? 50'(-v) : 50'(v);
        q   = (mag + 50'h4000) >> 15;
        q36 = q[35:0];
        return v[49] ? -$signed(q36) : $signed(q36);
    endfunction

endpackage

// ----- src/edr_mul.sv -----
// Shared sign-magnitude multiplier with registered product and rounding shift.
module edr_mul import edr_pkg::*; (
    input  logic                   aclk,
    input  edr_mul_ctl_t           ctl,
    input  logic signed [MA_W-1:0] a,
    input  logic signed [MB_W-1:0] b,
    output logic signed [MR_W-1:0] res
);

    logic [MA_W-1:0] mag_a;
    logic [MB_W-1:0] mag_b;
    logic [MP_W-1:0] prod_reg;
    logic            neg_reg;
    edr_shift_t      shift_reg;
    logic [MP_W-1:0] half;
    logic [4:0]      shamt;
    logic [MP_W-1:0] rounded;

    assign mag_a = a[MA_W-1] ? MA_W'(-a) : MA_W'(a);
    assign mag_b = b[MB_W-1] ? MB_W'(-b) : MB_W'(b);

    always_ff @(posedge aclk) begin
        if (ctl.start) begin
            prod_reg  <= MP_W'(mag_a) * MP_W'(mag_b);
            neg_reg   <= a[MA_W-1] ^ b[MB_W-1];
            shift_reg <= ctl.shift;
        end
    end

    always_comb begin
        case (shift_reg)
            SH_Q15: begin
                half  = MP_W'(1) << 14;
                shamt = 5'd15;
            end
            SH_Q30: begin
                half  = MP_W'(1) << 29;
                shamt = 5'd30;
            end
            default: begin
                half  = '0;
                shamt = 5'd0;
            end
        endcase
        rounded = (prod_reg + half) >> shamt;
        res     = neg_reg ? -$signed({1'b0, rounded}) : $signed({1'b0, rounded});
    end

endmodule

// ----- src/edr_sat.sv -----
// Saturating add of a displacement to a position coordinate.
module edr_sat import edr_pkg::*; #(
    parameter int POSITION_BITS = POSITION_BITS_DEF
) (
    input  logic signed [POSITION_BITS-1:0] base,
    input  logic signed [DISP_W-1:0]        delta,
    output logic signed [POSITION_BITS-1:0] sum,
    output logic                            clamped
);

    localparam int SW = ((POSITION_BITS > DISP_W) ? POSITION_BITS : DISP_W) + 1;

    logic signed [SW-1:0] wide;
    logic signed [SW-1:0] max_v;
    logic signed [SW-1:0] min_v;

    assign wide  = SW'(base) + SW'(delta);
    assign max_v = $signed({{(SW-POSITION_BITS+1){1'b0}}, {(POSITION_BITS-1){1'b1}}});
    assign min_v = ~max_v;

    always_comb begin
        if (wide > max_v) begin
            sum     = max_v[POSITION_BITS-1:0];
            clamped = 1'b1;
        end else if (wide < min_v) begin
            sum     = min_v[POSITION_BITS-1:0];
            clamped = 1'b1;
        end else begin
            sum     = wide[POSITION_BITS-1:0];
            clamped = 1'b0;
        end
    end

endmodule

// ----- src/euler_dead_reckoning_with_gps_reset_core.sv -----
// Top level of the Z-Y-X Euler dead-reckoning navigator with GPS position reset.
//
// Usage. An input word on s_valid/s_ready carries yaw, pitch and roll as binary
// angles, the body-frame water velocity, a time step and an optional GPS fix.
// The core takes one word when s_ready is high and then holds s_ready low while
// it works. One multiplier, shared by all steps, first evaluates six sines and
// cosines (six products each), then the rotation matrix, the world velocity and
// the displacement (twenty products). A saturating adder then updates X and Y
// and applies the GPS reset, one coordinate a cycle, the last one waiting for
// a free output slot. s_ready returns in the same cycle that a result word
// appears on m_valid/m_data, so the core takes no new word before the last
// result is formed.
// The result sits in an output register: a stalled receiver does not stop the
// next input word, and only a second result waits for m_ready.
// The configuration port (cfg_valid/cfg_ready, always ready) writes the east
// and north reference registers; unknown indexes are ignored.
// Synchronous reset (aresetn low) clears the position, the references and all
// handshake state. No result is in flight afterwards.
`include "euler_dead_reckoning_with_gps_reset_core_assert.svh"

module euler_dead_reckoning_with_gps_reset_core import edr_pkg::*; #(
    parameter int ANGLE_BITS    = ANGLE_BITS_DEF,
    parameter int POSITION_BITS = POSITION_BITS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  edr_in_t           s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output edr_out_t          m_data,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [CIDX_W-1:0] cfg_index,
    input  logic [REF_W-1:0]  cfg_data
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SIN,
        ST_MAT,
        ST_POS
    } state_t;

    localparam logic [2:0] LAST_ANG = 3'd5;
    localparam logic [2:0] LAST_SUB = 3'd5;
    localparam logic [4:0] LAST_OP  = 5'd19;
    localparam logic [ANGLE_BITS-1:0] QUARTER = {2'b01, {(ANGLE_BITS-2){1'b0}}};

    state_t     state_reg;
    logic [2:0] ang_reg;
    logic [2:0] sub_reg;
    logic [4:0] op_reg;
    logic [1:0] pos_reg;
    logic       ph_reg;

    edr_in_t          in_reg;
    logic [REF_W-1:0] east_ref_reg;
    logic [REF_W-1:0] north_ref_reg;

    logic signed [15:0] sq_reg [6];
    logic [30:0]        x2_reg;
    logic signed [31:0] t_reg;
    logic signed [31:0] cysp_reg;
    logic signed [31:0] sysp_reg;
    logic signed [32:0] r00_reg, r01_reg, r02_reg, r10_reg, r11_reg, r12_reg;
    logic signed [49:0] acc_reg;
    logic signed [33:0] wx_reg, wy_reg;
    logic signed [DISP_W-1:0] dx_reg, dy_reg;

    logic signed [POSITION_BITS-1:0] pos_x_reg, pos_y_reg;
    logic signed [POSITION_BITS-1:0] dead_x_reg, dead_y_reg;
    logic                            sat_reg;

    logic     m_valid_reg;
    edr_out_t m_data_reg;

    // Angle of the current sine or cosine evaluation, mapped to a quarter wave.
    logic [ANGLE_BITS-1:0] ang_base;
    logic [ANGLE_BITS-1:0] ang_sel;
    logic [31:0]           phase_u;
    logic [1:0]            quad;
    logic [30:0]           x_sin;

    always_comb begin
        case (ang_reg[2:1])
            2'd0:    ang_base = ANGLE_BITS'(in_reg.yaw_angle);
            2'd1:    ang_base = ANGLE_BITS'($unsigned(in_reg.pitch_angle));
            default: ang_base = ANGLE_BITS'($unsigned(in_reg.roll_angle));
        endcase
        ang_sel = ang_base + (ang_reg[0] ? QUARTER : '0);
        phase_u = {ang_sel, {(32-ANGLE_BITS){1'b0}}};
        quad    = phase_u[31:30];
        x_sin   = quad[0] ? (Q30_ONE - {1'b0, phase_u[29:0]}) : {1'b0, phase_u[29:0]};
    end

    // Sine and cosine values in slot order: sy, cy, sp, cp, sr, cr.
    logic signed [15:0] sy, cy, sp, cp, sr, cr;
    assign sy = sq_reg[0];
    assign cy = sq_reg[1];
    assign sp = sq_reg[2];
    assign cp = sq_reg[3];
    assign sr = sq_reg[4];
    assign cr = sq_reg[5];

    // Shared multiplier and its operand selection.
    edr_mul_ctl_t           mul_ctl;
    logic signed [MA_W-1:0] mul_a;
    logic signed [MB_W-1:0] mul_b;
    logic signed [MR_W-1:0] mres;
    logic signed [31:0]     sin_coef;

    always_comb begin
        mul_a         = '0;
        mul_b         = '0;
        mul_ctl.shift = SH_NONE;
        mul_ctl.start = ((state_reg == ST_SIN) || (state_reg == ST_MAT)) && !ph_reg;
        sin_coef      = C_A1;
        case (sub_reg)
            3'd1:    sin_coef = C_A7;
            3'd2:    sin_coef = C_A5;
            3'd3:    sin_coef = C_A3;
            default: sin_coef = C_A1;
        endcase
        case (state_reg)
            ST_SIN: begin
                mul_ctl.shift = SH_Q30;
                case (sub_reg)
                    3'd0: begin
                        mul_a = MA_W'(x_sin);
                        mul_b = MB_W'(x_sin);
                    end
                    3'd1: begin
                        mul_a = MA_W'(C_A9);
                        mul_b = MB_W'(x2_reg);
                    end
                    3'd5: begin
                        mul_a = MA_W'(t_reg);
                        mul_b = MB_W'(x_sin);
                    end
                    default: begin
                        mul_a = MA_W'(t_reg);
                        mul_b = MB_W'(x2_reg);
                    end
                endcase
            end
            ST_MAT: begin
                case (op_reg)
                    5'd0: begin mul_a = MA_W'(cy); mul_b = MB_W'(sp); end
                    5'd1: begin mul_a = MA_W'(sy); mul_b = MB_W'(sp); end
                    5'd2: begin mul_a = MA_W'(cy); mul_b = MB_W'(cp); end
                    5'd3: begin mul_a = MA_W'(sy); mul_b = MB_W'(cp); end
                    5'd4: begin
                        mul_a = MA_W'(cysp_reg); mul_b = MB_W'(sr); mul_ctl.shift = SH_Q15;
                    end
                    5'd5: begin mul_a = MA_W'(sy); mul_b = MB_W'(cr); end
                    5'd6: begin
                        mul_a = MA_W'(cysp_reg); mul_b = MB_W'(cr); mul_ctl.shift = SH_Q15;
                    end
                    5'd7: begin mul_a = MA_W'(sy); mul_b = MB_W'(sr); end
                    5'd8: begin
                        mul_a = MA_W'(sysp_reg); mul_b = MB_W'(sr); mul_ctl.shift = SH_Q15;
                    end
                    5'd9: begin mul_a = MA_W'(cy); mul_b = MB_W'(cr); end
                    5'd10: begin
                        mul_a = MA_W'(sysp_reg); mul_b = MB_W'(cr); mul_ctl.shift = SH_Q15;
                    end
                    5'd11: begin mul_a = MA_W'(cy); mul_b = MB_W'(sr); end
                    5'd12: begin mul_a = MA_W'(r00_reg); mul_b = MB_W'(in_reg.vel_forward); end
                    5'd13: begin mul_a = MA_W'(r01_reg); mul_b = MB_W'(in_reg.vel_starboard); end
                    5'd14: begin mul_a = MA_W'(r02_reg); mul_b = MB_W'(in_reg.vel_down); end
                    5'd15: begin mul_a = MA_W'(r10_reg); mul_b = MB_W'(in_reg.vel_forward); end
                    5'd16: begin mul_a = MA_W'(r11_reg); mul_b = MB_W'(in_reg.vel_starboard); end
                    5'd17: begin mul_a = MA_W'(r12_reg); mul_b = MB_W'(in_reg.vel_down); end
                    5'd18: begin
                        mul_a = MA_W'(wx_reg); mul_b = MB_W'(in_reg.step_time);
                        mul_ctl.shift = SH_Q15;
                    end
                    default: begin
                        mul_a = MA_W'(wy_reg); mul_b = MB_W'(in_reg.step_time);
                        mul_ctl.shift = SH_Q15;
                    end
                endcase
            end
            default: ;
        endcase
    end

    edr_mul u_mul (
        .aclk (aclk),
        .ctl  (mul_ctl),
        .a    (mul_a),
        .b    (mul_b),
        .res  (mres)
    );

    // Views of the product at the widths that each destination needs.
    logic signed [31:0] mr32;
    logic signed [32:0] mr33;
    logic signed [49:0] mr50;
    logic signed [35:0] sin_rnd;
    logic signed [15:0] sin_val;
    logic signed [35:0] acc_rnd;

    assign mr32    = $signed(mres[31:0]);
    assign mr33    = $signed(mres[32:0]);
    assign mr50    = $signed(mres[49:0]);
    assign sin_rnd = rnd15(mr50);
    assign acc_rnd = rnd15(acc_reg);

    // Clamp the sine magnitude to Q1.15, then apply the quadrant's sign.
    always_comb begin
        logic signed [15:0] mag;
        if (sin_rnd < 0) begin
            mag = '0;
        end else if (sin_rnd > 36'sd32767) begin
            mag = 16'sd32767;
        end else begin
            mag = sin_rnd[15:0];
        end
        sin_val = quad[1] ? -mag : mag;
    end

    // Saturating adder, shared by the dead-reckoning update and the GPS reset.
    logic signed [POSITION_BITS-1:0] sat_base;
    logic signed [DISP_W-1:0]        sat_delta;
    logic signed [POSITION_BITS-1:0] sat_sum;
    logic                            sat_clamped;
    logic signed [REF_W:0]           gps_e, gps_n;

    assign gps_e = $signed({1'b0, in_reg.utm_east_mm}) - $signed({1'b0, east_ref_reg});
    assign gps_n = $signed({1'b0, in_reg.utm_north_mm}) - $signed({1'b0, north_ref_reg});

    always_comb begin
        case (pos_reg)
            2'd0: begin sat_base = pos_x_reg; sat_delta = dx_reg; end
            2'd1: begin sat_base = pos_y_reg; sat_delta = dy_reg; end
            2'd2: begin sat_base = '0; sat_delta = DISP_W'(gps_e); end
            default: begin sat_base = '0; sat_delta = DISP_W'(gps_n); end
        endcase
    end

    edr_sat #(
        .POSITION_BITS (POSITION_BITS)
    ) u_sat (
        .base    (sat_base),
        .delta   (sat_delta),
        .sum     (sat_sum),
        .clamped (sat_clamped)
    );

    // The result word is loaded on the last position step once the output slot is free.
    logic out_load;
    logic signed [63:0] ext_dx, ext_dy, ext_nx, ext_ny;
    logic signed [POSITION_BITS-1:0] nav_y_val;

    assign out_load  = (state_reg == ST_POS) && (pos_reg == 2'd3) && (!m_valid_reg || m_ready);
    assign nav_y_val = in_reg.gps_fix ? sat_sum : pos_y_reg;
    assign ext_dx    = 64'(dead_x_reg);
    assign ext_dy    = 64'(dead_y_reg);
    assign ext_nx    = 64'(pos_x_reg);
    assign ext_ny    = 64'(nav_y_val);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            ang_reg       <= '0;
            sub_reg       <= '0;
            op_reg        <= '0;
            pos_reg       <= '0;
            ph_reg        <= 1'b0;
            m_valid_reg   <= 1'b0;
            east_ref_reg  <= '0;
            north_ref_reg <= '0;
            pos_x_reg     <= '0;
            pos_y_reg     <= '0;
            sat_reg       <= 1'b0;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    CFG_EAST_REF:  east_ref_reg  <= cfg_data;
                    CFG_NORTH_REF: north_ref_reg <= cfg_data;
                    default: ;
                endcase
            end

            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        in_reg    <= s_data;
                        state_reg <= ST_SIN;
                        ang_reg   <= '0;
                        sub_reg   <= '0;
                        ph_reg    <= 1'b0;
                        sat_reg   <= 1'b0;
                    end
                end
                ST_SIN: begin
                    ph_reg <= !ph_reg;
                    if (ph_reg) begin
                        case (sub_reg)
                            3'd0:    x2_reg <= mres[30:0];
                            3'd5:    sq_reg[ang_reg] <= sin_val;
                            default: t_reg <= sin_coef + mr32;
                        endcase
                        if (sub_reg == LAST_SUB) begin
                            sub_reg <= '0;
                            if (ang_reg == LAST_ANG) begin
                                state_reg <= ST_MAT;
                                op_reg    <= '0;
                            end else begin
                                ang_reg <= ang_reg + 3'd1;
                            end
                        end else begin
                            sub_reg <= sub_reg + 3'd1;
                        end
                    end
                end
                ST_MAT: begin
                    ph_reg <= !ph_reg;
                    if (ph_reg) begin
                        case (op_reg)
                            5'd0:  cysp_reg <= mr32;
                            5'd1:  sysp_reg <= mr32;
                            5'd2:  r00_reg  <= mr33;
                            5'd3:  r10_reg  <= mr33;
                            5'd4:  r01_reg  <= mr33;
                            5'd5:  r01_reg  <= r01_reg - mr33;
                            5'd6:  r02_reg  <= mr33;
                            5'd7:  r02_reg  <= r02_reg + mr33;
                            5'd8:  r11_reg  <= mr33;
                            5'd9:  r11_reg  <= r11_reg + mr33;
                            5'd10: r12_reg  <= mr33;
                            5'd11: r12_reg  <= r12_reg - mr33;
                            5'd12: acc_reg  <= mr50;
                            5'd15: begin
                                wx_reg  <= acc_rnd[33:0];
                                acc_reg <= mr50;
                            end
                            5'd18: begin
                                dx_reg <= mres[DISP_W-1:0];
                                wy_reg <= acc_rnd[33:0];
                            end
                            5'd19: dy_reg <= mres[DISP_W-1:0];
                            default: acc_reg <= acc_reg + mr50;
                        endcase
                        if (op_reg == LAST_OP) begin
                            state_reg <= ST_POS;
                            pos_reg   <= '0;
                        end else begin
                            op_reg <= op_reg + 5'd1;
                        end
                    end
                end
                ST_POS: begin
                    case (pos_reg)
                        2'd0: begin
                            pos_x_reg  <= sat_sum;
                            dead_x_reg <= sat_sum;
                            sat_reg    <= sat_reg | sat_clamped;
                            pos_reg    <= 2'd1;
                        end
                        2'd1: begin
                            pos_y_reg  <= sat_sum;
                            dead_y_reg <= sat_sum;
                            sat_reg    <= sat_reg | sat_clamped;
                            pos_reg    <= 2'd2;
                        end
                        2'd2: begin
                            if (in_reg.gps_fix) begin
                                pos_x_reg <= sat_sum;
                                sat_reg   <= sat_reg | sat_clamped;
                            end
                            pos_reg <= 2'd3;
                        end
                        default: begin
                            if (out_load) begin
                                pos_y_reg <= nav_y_val;
                                m_data_reg.dead_x    <= ext_dx[OUT_W-1:0];
                                m_data_reg.dead_y    <= ext_dy[OUT_W-1:0];
                                m_data_reg.nav_x     <= ext_nx[OUT_W-1:0];
                                m_data_reg.nav_y     <= ext_ny[OUT_W-1:0];
                                m_data_reg.gps_used  <= in_reg.gps_fix;
                                m_data_reg.saturated <= sat_reg |
                                                        (in_reg.gps_fix & sat_clamped);
                                state_reg <= ST_IDLE;
                            end
                        end
                    endcase
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_ready   = (state_reg == ST_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;
    assign cfg_ready = 1'b1;

    // Once a word is taken the core stays busy until its result is formed.
    `EDR_ASSERT_NXT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready, !s_ready, "core took a second word while busy")
    // A new result never overwrites one that the receiver has not taken.
    `EDR_ASSERT_IMP(a_load_slot_free, aclk, aresetn, out_load, !m_valid_reg || m_ready, "result overwritten before it was taken")
    // Sequencer counters stay within their programs.
    `EDR_ASSERT_IMP(a_sin_range, aclk, aresetn, state_reg == ST_SIN, (ang_reg <= LAST_ANG) && (sub_reg <= LAST_SUB), "sine sequencer out of range")
    `EDR_ASSERT_IMP(a_op_range, aclk, aresetn, state_reg == ST_MAT, op_reg <= LAST_OP, "matrix sequencer out of range")

endmodule

// ----- test/tb.sv -----
// Self-checking testbench for the Euler dead-reckoning core with GPS reset.
`timescale 1ns / 100ps

module tb;
    import edr_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int POS_W = 48;

    logic            aclk;
    logic            aresetn;
    logic            s_valid;
    logic            s_ready;
    edr_in_t         s_data;
    logic            m_valid;
    logic            m_ready;
    edr_out_t        m_data;
    logic            cfg_valid;
    logic            cfg_ready;
    logic [CIDX_W-1:0] cfg_index;
    logic [REF_W-1:0]  cfg_data;

    euler_dead_reckoning_with_gps_reset_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    // Words waiting to be sent, and the navigation results they should produce.
    edr_in_t  pending_words[$];
    edr_out_t nav_expected[$];

    // Register writes requested by the stimulus process; the driver
    // performs them, so only one process drives the configuration port.
    logic [CIDX_W-1:0] cfg_req_index[$];
    logic [REF_W-1:0]  cfg_req_data[$];

    // Predictor state: references and the stored position.
    logic [REF_W-1:0]        east_ref, north_ref;
    logic signed [63:0]      track_x, track_y;

    int send_idle_pct, recv_stall_pct;
    int mismatches, accepted_in, accepted_out;
    int quiet_cycles;
    bit timed_out;

    // Rounding right shift, half away from zero.
    function automatic logic signed [63:0] round_shift(input logic signed [63:0] v,
                                                       input int sh);
        logic [63:0] m;
        m = v[63] ? -v : v;
        m = (m + (64'd1 << (sh - 1))) >> sh;
        return v[63] ? -$signed(m) : $signed(m);
    endfunction

    function automatic logic signed [63:0] q30_product(input logic signed [63:0] a,
                                                       input logic signed [63:0] b);
        logic [63:0] ma, mb, p;
        ma = a[63] ? -a : a;
        mb = b[63] ? -b : b;
        p  = (ma * mb + (64'd1 << 29)) >> 30;
        return (a[63] != b[63]) ? -$signed(p) : $signed(p);
    endfunction

    function automatic logic signed [63:0] sine_q15(input logic [15:0] ang);
        logic [31:0] u;
        logic [1:0]  quad;
        logic signed [63:0] x, x2, t, s;
        u    = {ang, 16'd0};
        quad = u[31:30];
        x    = {34'd0, u[29:0]};
        if (quad[0]) begin
            x = 64'sd1073741824 - x;
        end
        x2 = q30_product(x, x);
        t  = 64'(C_A9);
        t  = 64'(C_A7) + q30_product(t, x2);
        t  = 64'(C_A5) + q30_product(t, x2);
        t  = 64'(C_A3) + q30_product(t, x2);
        t  = 64'(C_A1) + q30_product(t, x2);
        s  = round_shift(q30_product(t, x), 15);
        if (s < 0) begin
            s = 0;
        end
        if (s > 32767) begin
            s = 32767;
        end
        return quad[1] ? -s : s;
    endfunction

    function automatic logic signed [63:0] clamp_add(input logic signed [63:0] p,
                                                     input logic signed [63:0] d,
                                                     inout bit sat);
        logic signed [63:0] mx, mn, r;
        mx = (64'sd1 <<< (POS_W - 1)) - 1;
        mn = -mx - 1;
        r  = p + d;
        if (r > mx) begin
            sat = 1'b1;
            return mx;
        end
        if (r < mn) begin
            sat = 1'b1;
            return mn;
        end
        return r;
    endfunction

    // Advances the position by one word and returns the navigation result.
    function automatic edr_out_t navigate(input edr_in_t w);
        logic signed [63:0] sy, cy, sp, cp, sr, cr, vf, vs, vd, dt;
        logic signed [63:0] cysp, sysp, r00, r01, r02, r10, r11, r12;
        logic signed [63:0] wx, wy, dx, dy;
        bit sat;
        edr_out_t r;
        sat  = 1'b0;
        sy   = sine_q15(w.yaw_angle);
        cy   = sine_q15(w.yaw_angle + 16'h4000);
        sp   = sine_q15(w.pitch_angle);
        cp   = sine_q15(w.pitch_angle + 16'h4000);
        sr   = sine_q15(w.roll_angle);
        cr   = sine_q15(w.roll_angle + 16'h4000);
        vf   = 64'(w.vel_forward);
        vs   = 64'(w.vel_starboard);
        vd   = 64'(w.vel_down);
        dt   = {48'd0, w.step_time};
        cysp = cy * sp;
        sysp = sy * sp;
        r00  = cy * cp;
        r01  = round_shift(cysp * sr, 15) - sy * cr;
        r02  = round_shift(cysp * cr, 15) + sy * sr;
        r10  = sy * cp;
        r11  = round_shift(sysp * sr, 15) + cy * cr;
        r12  = round_shift(sysp * cr, 15) - cy * sr;
        wx   = round_shift(r00 * vf + r01 * vs + r02 * vd, 15);
        wy   = round_shift(r10 * vf + r11 * vs + r12 * vd, 15);
        dx   = round_shift(dt * wx, 15);
        dy   = round_shift(dt * wy, 15);
        track_x = clamp_add(track_x, dx, sat);
        track_y = clamp_add(track_y, dy, sat);
        r.dead_x = track_x[POS_W-1:0];
        r.dead_y = track_y[POS_W-1:0];
        if (w.gps_fix) begin
            track_x = clamp_add(0, $signed({30'd0, w.utm_east_mm})
                                   - $signed({30'd0, east_ref}), sat);
            track_y = clamp_add(0, $signed({30'd0, w.utm_north_mm})
                                   - $signed({30'd0, north_ref}), sat);
        end
        r.nav_x     = track_x[POS_W-1:0];
        r.nav_y     = track_y[POS_W-1:0];
        r.gps_used  = w.gps_fix;
        r.saturated = sat;
        return r;
    endfunction

    // Driver: input words and register writes, driven at the rising edge.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid   <= 1'b0;
            cfg_valid <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                void'(cfg_req_index.pop_front());
                void'(cfg_req_data.pop_front());
            end
            if (cfg_req_index.size() > ((cfg_valid && cfg_ready) ? 1 : 0)) begin
                cfg_valid <= 1'b1;
                cfg_index <= cfg_req_index[(cfg_valid && cfg_ready) ? 1 : 0];
                cfg_data  <= cfg_req_data[(cfg_valid && cfg_ready) ? 1 : 0];
            end else begin
                cfg_valid <= 1'b0;
            end
            if (s_valid && s_ready) begin
                nav_expected.push_back(navigate(s_data));
                void'(pending_words.pop_front());
                accepted_in++;
            end
            if (!s_valid || s_ready) begin
                if (pending_words.size() > ((s_valid && s_ready) ? 1 : 0)
                    && $urandom_range(99) >= send_idle_pct) begin
                    s_valid <= 1'b1;
                    s_data  <= pending_words[(s_valid && s_ready) ? 1 : 0];
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Register writes update the predictor copy as they are accepted.
    always @(posedge aclk) begin
        if (aresetn && cfg_valid && cfg_ready) begin
            if (cfg_index == CFG_EAST_REF) begin
                east_ref <= cfg_data;
            end else if (cfg_index == CFG_NORTH_REF) begin
                north_ref <= cfg_data;
            end
        end
    end

    // Monitor: compares each result word with the oldest expectation.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                accepted_out++;
                if (nav_expected.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("Unexpected result word %p", m_data);
                    end
                end else begin
                    edr_out_t want;
                    want = nav_expected.pop_front();
                    if (m_data !== want) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("Mismatch: expected %p", want);
                            $display("          actual   %p", m_data);
                        end
                    end
                end
            end
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog: counts cycles in which no word moves on either channel.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)
            || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic edr_in_t random_word();
        edr_in_t w;
        w = '{default: '0};
        w.yaw_angle     = 16'($urandom);
        w.pitch_angle   = 16'($urandom);
        w.roll_angle    = 16'($urandom);
        w.vel_forward   = 16'($urandom);
        w.vel_starboard = 16'($urandom);
        w.vel_down      = 16'($urandom);
        // Mostly short steps, sometimes the full range.
        w.step_time     = ($urandom_range(3) == 0) ? 16'($urandom)
                                                   : 16'($urandom_range(200));
        w.gps_fix       = ($urandom_range(9) == 0);
        w.utm_east_mm   = REF_W'({$urandom, $urandom});
        w.utm_north_mm  = REF_W'({$urandom, $urandom});
        return w;
    endfunction

    task automatic write_ref(input logic [CIDX_W-1:0] idx, input logic [REF_W-1:0] val);
        cfg_req_index.push_back(idx);
        cfg_req_data.push_back(val);
    endtask

    // Waits until every word has gone through and the core is idle again.
    task automatic drain();
        while ((pending_words.size() != 0 || nav_expected.size() != 0 || s_valid
                || cfg_req_index.size() != 0) && !timed_out) begin
            @(posedge aclk);
        end
        repeat (150) @(posedge aclk);
    endtask

    task automatic run_phase(input int count, input int idle, input int stall);
        send_idle_pct  = idle;
        recv_stall_pct = stall;
        repeat (count) begin
            pending_words.push_back(random_word());
        end
        drain();
    endtask

    initial begin
        edr_in_t w;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        m_ready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        east_ref = '0;
        north_ref = '0;
        track_x = 0;
        track_y = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        mismatches = 0;
        accepted_in = 0;
        accepted_out = 0;
        quiet_cycles = 0;
        timed_out = 1'b0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed words: eighth-turn yaw steps, field extremes and fixes.
        for (int k = 0; k < 8; k++) begin
            w = '{default: '0};
            w.yaw_angle     = 16'(k * 16'h2000);
            w.pitch_angle   = 16'(k * 16'h4000 + 16'h1000);
            w.roll_angle    = (k[0]) ? 16'sh8000 : 16'sh7fff;
            w.vel_forward   = (k[1]) ? 16'sh8000 : 16'sh7fff;
            w.vel_starboard = (k[2]) ? 16'sh7fff : 16'sh8000;
            w.vel_down      = 16'sh8000;
            w.step_time     = (k > 3) ? 16'hffff : 16'd1;
            pending_words.push_back(w);
        end
        // Drive the position toward the positive limit.
        w = '{default: '0};
        w.vel_forward = 16'sh7fff;
        w.vel_starboard = 16'sh7fff;
        w.yaw_angle = 16'h2000;
        w.step_time = 16'hffff;
        // Fix that loads a huge offset, then keep pushing toward the limit.
        w.gps_fix = 1'b1;
        w.utm_east_mm = '1;
        w.utm_north_mm = '1;
        pending_words.push_back(w);
        w.gps_fix = 1'b0;
        repeat (3) pending_words.push_back(w);
        w.gps_fix = 1'b1;
        w.utm_east_mm = '0;
        w.utm_north_mm = 34'h2_0000_0000;
        pending_words.push_back(w);
        drain();

        // References at both extremes, then the accumulator near its limit.
        write_ref(CFG_EAST_REF, '1);
        write_ref(CFG_NORTH_REF, '1);
        write_ref(2'd2, 34'h1234);
        write_ref(2'd3, 34'h5678);
        drain();
        w = '{default: '0};
        w.gps_fix = 1'b1;
        w.utm_east_mm = '0;
        w.utm_north_mm = '1;
        pending_words.push_back(w);
        w.gps_fix = 1'b0;
        w.vel_forward = 16'sh8000;
        w.vel_starboard = 16'sh8000;
        w.yaw_angle = 16'h2000;
        w.step_time = 16'hffff;
        repeat (4) pending_words.push_back(w);
        drain();

        // Random phases with different references and idling patterns.
        write_ref(CFG_EAST_REF, '0);
        write_ref(CFG_NORTH_REF, 34'h1_0000_0000);
        drain();
        run_phase(450, 0, 0);
        write_ref(CFG_EAST_REF, REF_W'({$urandom, $urandom}));
        write_ref(CFG_NORTH_REF, REF_W'({$urandom, $urandom}));
        drain();
        run_phase(400, 77, 0);
        write_ref(CFG_EAST_REF, 34'h2_0000_0000);
        write_ref(CFG_NORTH_REF, '0);
        drain();
        run_phase(400, 0, 77);
        write_ref(CFG_EAST_REF, REF_W'({$urandom, $urandom}));
        write_ref(CFG_NORTH_REF, '1);
        drain();
        run_phase(400, 11, 11);

        if (mismatches == 0 && nav_expected.size() == 0 && !timed_out) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        timed_out = 1'b1;
        $display("FAIL");
        $finish;
    end

endmodule
